@@ src/vdsd_pkg.sv @@
// shared types and constants for the varint delta stream decoder
package vdsd_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int VALUE_W        = 64;
	localparam int POS_W          = 16;
	localparam int BCNT_W         = 20;
	localparam int GRP_W          = 4;

	localparam logic [BCNT_W-1:0] BYTE_CNT_MAX  = '1;
	localparam logic [6:0]        GROUP_MASK    = 7'h7F;
	localparam logic [GRP_W-1:0]  LAST_GRP_WIDE = 4'd9;
	localparam logic [GRP_W-1:0]  LAST_GRP_NARW = 4'd4;
	localparam logic [VALUE_W-1:0] LO32_MASK    = 64'h0000_0000_FFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_MODE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_INDEX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_KEY   = 3'd5;

	localparam logic [1:0] QM_DECODE = 2'd0;
	localparam logic [1:0] QM_SELECT = 2'd1;
	localparam logic [1:0] QM_SEARCH = 2'd2;

	typedef struct packed {
		logic [1:0]         query_mode;
		logic               delta_mode;
		logic               wide_mode;
		logic [POS_W-1:0]   value_count;
		logic [POS_W-1:0]   select_index;
		logic [VALUE_W-1:0] search_key;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic               found;
		logic [BCNT_W-1:0]  bytes_used;
		logic               last;
	} res_t;

endpackage

@@ src/vdsd_cfg.sv @@
// configuration registers of the decoder
module vdsd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [vdsd_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [vdsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output vdsd_pkg::cfg_t                      cfg
);

	vdsd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.query_mode   <= vdsd_pkg::QM_DECODE;
			cfg_q.delta_mode   <= 1'b0;
			cfg_q.wide_mode    <= 1'b1;
			cfg_q.value_count  <= 16'd1;
			cfg_q.select_index <= '0;
			cfg_q.search_key   <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				vdsd_pkg::REG_QUERY_MODE:   cfg_q.query_mode   <= cfg_wdata[1:0];
				vdsd_pkg::REG_DELTA_MODE:   cfg_q.delta_mode   <= cfg_wdata[0];
				vdsd_pkg::REG_WIDE_MODE:    cfg_q.wide_mode    <= cfg_wdata[0];
				vdsd_pkg::REG_VALUE_COUNT:  cfg_q.value_count  <= cfg_wdata[15:0];
				vdsd_pkg::REG_SELECT_INDEX: cfg_q.select_index <= cfg_wdata[15:0];
				vdsd_pkg::REG_SEARCH_KEY:   cfg_q.search_key   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/vdsd_in_reg.sv @@
// input register stage holding one byte item
module vdsd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       start_req,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       start_s1
);

	logic take;

	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= in_byte;
			start_s1 <= start_req;
		end
	end

endmodule

@@ src/vdsd_core.sv @@
// varint assembly, running sum and query logic with the run state
module vdsd_core #(
	parameter int COUNT_BITS = vdsd_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     byte_s1,
	input  logic           start_s1,
	input  vdsd_pkg::cfg_t cfg,
	output logic           has_res,
	output vdsd_pkg::res_t res
);

	localparam int CMP_W = (COUNT_BITS + 1 > vdsd_pkg::POS_W + 1) ?
		COUNT_BITS + 1 : vdsd_pkg::POS_W + 1;

	logic [vdsd_pkg::VALUE_W-1:0] pv_q, sum_q;
	logic [vdsd_pkg::GRP_W-1:0]   grp_q;
	logic [COUNT_BITS-1:0]        idx_q;
	logic [vdsd_pkg::BCNT_W-1:0]  bc_q;
	logic                         done_q;

	logic [vdsd_pkg::VALUE_W-1:0] pv_e, sum_e, vmask, ins, pv_new, sum_new, cur, key;
	logic [vdsd_pkg::GRP_W-1:0]   grp_e, last_grp;
	logic [COUNT_BITS-1:0]        idx_e;
	logic [vdsd_pkg::BCNT_W-1:0]  bc_e, bc_new;
	logic                         done_e, more, last_pos, hit, match;
	logic [6:0]                   shamt;
	logic [CMP_W-1:0]             idx_inc;
	logic [63:0]                  idx_wide;

	always_comb begin
		pv_e   = start_s1 ? '0 : pv_q;
		sum_e  = start_s1 ? '0 : sum_q;
		grp_e  = start_s1 ? '0 : grp_q;
		idx_e  = start_s1 ? '0 : idx_q;
		bc_e   = start_s1 ? '0 : bc_q;
		done_e = start_s1 ? 1'b0 : done_q;

		vmask    = cfg.wide_mode ? '1 : vdsd_pkg::LO32_MASK;
		last_grp = cfg.wide_mode ? vdsd_pkg::LAST_GRP_WIDE : vdsd_pkg::LAST_GRP_NARW;
		bc_new   = (bc_e < vdsd_pkg::BYTE_CNT_MAX) ? bc_e + 1'b1 : bc_e;

		shamt  = {3'b000, grp_e} * 7'd7;
		ins    = (grp_e <= vdsd_pkg::LAST_GRP_WIDE) ?
			(64'(byte_s1[6:0] & vdsd_pkg::GROUP_MASK) << shamt) : '0;
		pv_new = (pv_e | ins) & vmask;
		more   = byte_s1[7] && (grp_e < last_grp);

		sum_new  = (sum_e + pv_new) & vmask;
		cur      = cfg.delta_mode ? sum_new : pv_new;
		key      = cfg.search_key & vmask;
		idx_inc  = CMP_W'(idx_e) + 1'b1;
		last_pos = idx_inc >= CMP_W'(cfg.value_count);
		hit      = idx_e == COUNT_BITS'(cfg.select_index);
		match    = cfg.delta_mode ? (sum_new >= key) : (pv_new == key);
		idx_wide = 64'(idx_e);

		has_res        = 1'b0;
		res.value      = cur;
		res.position   = idx_wide[vdsd_pkg::POS_W-1:0];
		res.found      = 1'b1;
		res.bytes_used = bc_new;
		res.last       = 1'b1;

		if (!done_e && !more) begin
			case (cfg.query_mode)
				vdsd_pkg::QM_SELECT: begin
					has_res = hit;
				end
				vdsd_pkg::QM_SEARCH: begin
					has_res = match || last_pos;
					if (!match) begin
						res.value    = '0;
						res.position = cfg.value_count;
						res.found    = 1'b0;
					end
				end
				default: begin
					has_res  = 1'b1;
					res.last = last_pos;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			sum_q  <= '0;
			grp_q  <= '0;
			idx_q  <= '0;
			bc_q   <= '0;
			done_q <= 1'b1;
		end else if (fire && !done_e) begin
			bc_q <= bc_new;
			if (more) begin
				pv_q   <= pv_new;
				grp_q  <= grp_e + 1'b1;
				sum_q  <= sum_e;
				idx_q  <= idx_e;
				done_q <= 1'b0;
			end else begin
				pv_q   <= '0;
				grp_q  <= '0;
				sum_q  <= sum_new;
				idx_q  <= idx_e + 1'b1;
				done_q <= has_res && res.last;
			end
		end
	end

endmodule

@@ src/vdsd_out_reg.sv @@
// result register feeding the output channel
module vdsd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           has_res,
	input  vdsd_pkg::res_t res,
	output logic           can_take,
	output logic           out_valid,
	input  logic           out_ready,
	output vdsd_pkg::res_t res_q
);

	logic valid_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= fire && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && fire && has_res) begin
			res_q <= res;
		end
	end

endmodule

@@ src/varint_delta_stream_decoder.sv @@
// top level of the varint delta stream decoder
// Takes one compressed byte per cycle and never stalls while the result side
// is ready. A byte is held in the input register, then the decode logic
// (group shift and merge, 64-bit running-sum add, key compare) writes the
// result register, which shows the result for the byte that ends its value.
// The add followed by the compare sets the cycle time. in_ready drops
// only while a result waits to be taken and a byte is already held.
module varint_delta_stream_decoder #(
	parameter int COUNT_BITS = vdsd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [vdsd_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [vdsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_byte,
	input  logic                            start_req,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vdsd_pkg::VALUE_W-1:0]    value,
	output logic [vdsd_pkg::POS_W-1:0]      position,
	output logic                            found,
	output logic [vdsd_pkg::BCNT_W-1:0]     bytes_used,
	output logic                            last
);

	vdsd_pkg::cfg_t cfg;
	vdsd_pkg::res_t res, res_q;
	logic           valid_s1, start_s1, can_take, fire, has_res;
	logic [7:0]     byte_s1;

	vdsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vdsd_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.start_req (start_req),
		.advance   (can_take),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.start_s1  (start_s1)
	);

	assign fire = valid_s1 && can_take;

	vdsd_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.byte_s1  (byte_s1),
		.start_s1 (start_s1),
		.cfg      (cfg),
		.has_res  (has_res),
		.res      (res)
	);

	vdsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.has_res   (has_res),
		.res       (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign value      = res_q.value;
	assign position   = res_q.position;
	assign found      = res_q.found;
	assign bytes_used = res_q.bytes_used;
	assign last       = res_q.last;

endmodule

@@ src/vdsd_checker.sv @@
// port-level checks for the decoder and their binding
module vdsd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [vdsd_pkg::VALUE_W-1:0]    value,
	input logic                            found,
	input logic [vdsd_pkg::BCNT_W-1:0]     bytes_used,
	input logic                            last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(bytes_used))
		else $error("result changed while stalled");

	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last)
		else $error("failed search not marked last");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> value == '0)
		else $error("failed search with nonzero value");

	a_bytes_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bytes_used != '0)
		else $error("result without consumed bytes");

endmodule

bind varint_delta_stream_decoder vdsd_checker u_vdsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.value      (value),
	.found      (found),
	.bytes_used (bytes_used),
	.last       (last)
);
